/* hdl/pgm_pkg.sv */
// Shared types, character codes and helper functions for the path glob matcher.
package pgm_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR_PATTERN = 2'd0,
		CMD_APPEND_PATTERN = 2'd1,
		CMD_APPEND_TEXT = 2'd2,
		CMD_EVALUATE = 2'd3
	} command_t;

	typedef struct packed {
		command_t command;
		logic [7:0] char_byte;
	} req_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL,
		ST_TAIL,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic eval;
		logic tail_step;
		logic tail_done;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic overflow;
		logic text_end;
		logic fail;
		logic tail_star;
	} dp_sts_t;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SLASH) || (c == CH_BACKSLASH);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
	endfunction

endpackage

/* hdl/pgm_ctrl.sv */
// Sequencing state machine of the path glob matcher.
module pgm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input pgm_pkg::command_t command,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input pgm_pkg::dp_sts_t sts,
	output pgm_pkg::dp_cmd_t cmd
);
	import pgm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.accept = req_valid;
				if (req_valid && command == CMD_EVALUATE) begin
					state_d = sts.overflow ? ST_RESULT : ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = sts.text_end ? ST_TAIL : ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d = sts.fail ? ST_RESULT : ST_FETCH;
			end
			ST_TAIL: begin
				if (sts.tail_star) begin
					cmd.tail_step = 1'b1;
					state_d = ST_FETCH;
				end else begin
					cmd.tail_done = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* hdl/pgm_datapath.sv */
// Pattern and text stores, match pointers and result register of the glob matcher.
module pgm_datapath #(
	parameter int PATTERN_MAX = 64,
	parameter int TEXT_MAX = 256
) (
	input logic clk,
	input logic arst_n,
	input pgm_pkg::req_t req,
	input pgm_pkg::dp_cmd_t cmd,
	output pgm_pkg::dp_sts_t sts,
	output pgm_pkg::rsp_t rsp
);
	import pgm_pkg::*;

	localparam int PLW = $clog2(PATTERN_MAX + 1);
	localparam int TLW = $clog2(TEXT_MAX + 1);
	localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int TAW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

	logic [7:0] pat_mem [PATTERN_MAX];
	logic [7:0] txt_mem [TEXT_MAX];

	logic [PLW-1:0] pat_len_q;
	logic [TLW-1:0] txt_len_q;
	logic pat_ovf_q;
	logic txt_ovf_q;

	logic [PLW-1:0] pc_q;
	logic [PLW-1:0] resume_q;
	logic [TLW-1:0] tc_q;
	logic [TLW-1:0] star_t_q;
	logic have_star_q;
	logic star_dbl_q;
	logic star_sep_q;
	logic sepchk_q;
	logic match_q;
	rsp_t rsp_q;

	logic [7:0] p0_q;
	logic [7:0] p1_q;
	logic [7:0] t_q;

	logic [PLW:0] pc1;
	logic pat_we;
	logic txt_we;
	logic pc_lt;
	logic pc1_lt;
	logic p_star;
	logic dbl;
	logic sep_skip;
	logic chr_ok;
	logic cur_star_sep;
	logic [PLW-1:0] resume_eff;
	logic fail;

	assign pc1 = {1'b0, pc_q} + {{PLW{1'b0}}, 1'b1};
	assign pat_we = cmd.accept && req.command == CMD_APPEND_PATTERN
		&& pat_len_q < PLW'(PATTERN_MAX);
	assign txt_we = cmd.accept && req.command == CMD_APPEND_TEXT
		&& txt_len_q < TLW'(TEXT_MAX);

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_len_q[PAW-1:0]] <= req.char_byte;
		end
		p0_q <= pat_mem[pc_q[PAW-1:0]];
		p1_q <= pat_mem[pc1[PAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (txt_we) begin
			txt_mem[txt_len_q[TAW-1:0]] <= req.char_byte;
		end
		t_q <= txt_mem[tc_q[TAW-1:0]];
	end

	assign pc_lt = pc_q < pat_len_q;
	assign pc1_lt = pc1 < {1'b0, pat_len_q};
	assign p_star = pc_lt && p0_q == CH_STAR;
	assign dbl = pc1_lt && p1_q == CH_STAR;
	assign sep_skip = sepchk_q && pc_lt && is_sep(p0_q);
	assign chr_ok = pc_lt && ((to_lower(p0_q) == to_lower(t_q))
		|| (p0_q == CH_QMARK && !is_sep(t_q))
		|| (is_sep(p0_q) && is_sep(t_q)));
	assign cur_star_sep = (tc_q == star_t_q) ? is_sep(t_q) : star_sep_q;
	assign resume_eff = sepchk_q ? pc_q : resume_q;
	assign fail = !sep_skip && !p_star && !chr_ok
		&& (!have_star_q || (!star_dbl_q && cur_star_sep));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= '0;
			txt_len_q <= '0;
			pat_ovf_q <= 1'b0;
			txt_ovf_q <= 1'b0;
			pc_q <= '0;
			resume_q <= '0;
			tc_q <= '0;
			star_t_q <= '0;
			have_star_q <= 1'b0;
			star_dbl_q <= 1'b0;
			star_sep_q <= 1'b0;
			sepchk_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				case (req.command)
					CMD_CLEAR_PATTERN: begin
						pat_len_q <= '0;
						pat_ovf_q <= 1'b0;
					end
					CMD_APPEND_PATTERN: begin
						if (pat_we) begin
							pat_len_q <= pat_len_q + 1'b1;
						end else begin
							pat_ovf_q <= 1'b1;
						end
					end
					CMD_APPEND_TEXT: begin
						if (txt_we) begin
							txt_len_q <= txt_len_q + 1'b1;
						end else begin
							txt_ovf_q <= 1'b1;
						end
					end
					CMD_EVALUATE: begin
						pc_q <= '0;
						tc_q <= '0;
						star_t_q <= '0;
						have_star_q <= 1'b0;
						sepchk_q <= 1'b0;
						match_q <= 1'b0;
					end
					default: begin
						match_q <= 1'b0;
					end
				endcase
			end
			if (cmd.eval) begin
				sepchk_q <= 1'b0;
				if (sep_skip) begin
					// Optional separator after a double star.
					pc_q <= pc1[PLW-1:0];
					resume_q <= pc1[PLW-1:0];
				end else begin
					if (sepchk_q) begin
						resume_q <= pc_q;
					end
					if (have_star_q && tc_q == star_t_q) begin
						star_sep_q <= is_sep(t_q);
					end
					if (p_star) begin
						have_star_q <= 1'b1;
						star_dbl_q <= dbl;
						star_t_q <= tc_q;
						star_sep_q <= is_sep(t_q);
						sepchk_q <= dbl;
						resume_q <= pc1[PLW-1:0];
						pc_q <= dbl ? pc_q + PLW'(2) : pc1[PLW-1:0];
					end else if (chr_ok) begin
						pc_q <= pc1[PLW-1:0];
						tc_q <= tc_q + 1'b1;
					end else if (!fail) begin
						// Backtrack: the last star takes one more text byte.
						star_t_q <= star_t_q + 1'b1;
						tc_q <= star_t_q + 1'b1;
						pc_q <= resume_eff;
					end
				end
			end
			if (cmd.tail_step) begin
				pc_q <= pc1[PLW-1:0];
			end
			if (cmd.tail_done) begin
				match_q <= pc_q == pat_len_q;
			end
			if (cmd.out_load) begin
				txt_len_q <= '0;
				txt_ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.matched <= match_q;
			rsp_q.overflow <= pat_ovf_q | txt_ovf_q;
		end
	end

	assign sts.overflow = pat_ovf_q | txt_ovf_q;
	assign sts.text_end = tc_q >= txt_len_q;
	assign sts.fail = fail;
	assign sts.tail_star = p_star;
	assign rsp = rsp_q;

endmodule

/* hdl/path_glob_matcher_unit.sv */
// Top level of the path glob matcher: controller and datapath joined.
// Clear and append transactions are accepted back to back.
// An evaluate transaction walks the stores in match steps, each a memory read state
// then a decision state; the walk length grows with backtracking to the star.
// The result register frees the input side as soon as a result is loaded into it.
// Reset clears lengths, overflow flags and control; store contents stay undefined.
module path_glob_matcher_unit #(
	parameter int PATTERN_MAX = 64,
	parameter int TEXT_MAX = 256
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input pgm_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output pgm_pkg::rsp_t rsp
);
	import pgm_pkg::*;

	// Command and status travel between the two halves as structs.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller decides when a transaction is taken and which step the
	// datapath performs; it also owns the valid flag of the result register.
	pgm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.command(req.command),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts(sts),
		.cmd(cmd)
	);

	// The datapath holds both stores, the match pointers with the star
	// bookmark, and the result payload.
	pgm_datapath #(
		.PATTERN_MAX(PATTERN_MAX),
		.TEXT_MAX(TEXT_MAX)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.sts(sts),
		.rsp(rsp)
	);

endmodule
